// ----- src/hwm_pkg.sv -----
`default_nettype none
package hwm_pkg;

	localparam int TABLE_SAMPLES = 256;
	localparam int MAX_HARMONICS = 16;
	localparam int PERIOD        = TABLE_SAMPLES - 1;
	localparam int TS_W          = $clog2(TABLE_SAMPLES);
	localparam int MH_W          = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
	localparam int HC_W          = 5;
	localparam int CMD_W         = 2;
	localparam int IDX_W         = 8;
	localparam int LEV_W         = 16;
	localparam int SIN_W         = 16;
	localparam int MIX_W         = 24;
	localparam int SMP_W         = 20;
	localparam int NUM_W         = 41;
	localparam int DEN_W         = MIX_W + 1;
	localparam int REM_W         = DEN_W + 1;
	localparam int DIV_STEPS     = NUM_W;
	localparam int DCNT_W        = $clog2(DIV_STEPS);

	localparam logic [CMD_W-1:0] CMD_SET_LEVEL = 2'd0;
	localparam logic [CMD_W-1:0] CMD_MIX       = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ      = 2'd2;

	localparam logic [63:0] Q30_ONE = 64'd1 << 30;
	localparam logic [63:0] K_C1 = 64'd1686629713;
	localparam logic [63:0] K_C3 = 64'd693598668;
	localparam logic [63:0] K_C5 = 64'd85569306;
	localparam logic [63:0] K_C7 = 64'd5026995;
	localparam logic [63:0] K_C9 = 64'd172272;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MIX,
		ST_NORM,
		ST_READ
	} ctrl_state_t;

	typedef enum logic [2:0] {
		NP_IDLE,
		NP_FETCH,
		NP_SETUP,
		NP_DIV,
		NP_WRITE
	} norm_phase_t;

	typedef struct packed {
		logic wr_level;
		logic start_mix;
		logic start_norm;
		logic rd_issue;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic mix_done;
		logic norm_done;
		logic out_valid;
	} dp_sts_t;

	typedef logic signed [SIN_W-1:0] sine_rom_t [PERIOD];

	function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
		return (a * b + (64'd1 << 29)) >> 30;
	endfunction

	// quarter-wave polynomial sine over one period of PERIOD points, Q1.15
	function automatic sine_rom_t sine_build();
		sine_rom_t   r;
		logic [63:0] ph;
		logic [63:0] f;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] y;
		logic [63:0] v;
		logic [1:0]  quad;
		for (int k = 0; k < PERIOD; k++) begin
			ph   = ((64'(k) << 32) + 64'(PERIOD / 2)) / 64'(PERIOD);
			quad = ph[31:30];
			f    = {34'd0, ph[29:0]};
			x    = quad[0] ? (Q30_ONE - f) : f;
			x2   = mul_q30(x, x);
			t    = K_C9;
			t    = K_C7 - mul_q30(x2, t);
			t    = K_C5 - mul_q30(x2, t);
			t    = K_C3 - mul_q30(x2, t);
			t    = K_C1 - mul_q30(x2, t);
			y    = mul_q30(x, t);
			v    = (y + 64'd16384) >> 15;
			if (v > 64'd32767) v = 64'd32767;
			r[k] = quad[1] ? -SIN_W'(v) : SIN_W'(v);
		end
		return r;
	endfunction

	localparam sine_rom_t SINE_ROM = sine_build();

endpackage
`default_nettype wire

// ----- src/hwm_ctrl.sv -----
`default_nettype none
module hwm_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [hwm_pkg::CMD_W-1:0] cmd,
	input  wire logic                      out_ready,
	input  wire hwm_pkg::dp_sts_t          sts,
	output hwm_pkg::dp_cmd_t               dcmd
);

	hwm_pkg::ctrl_state_t state_q, state_d;
	logic accept_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hwm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign accept_c = in_valid && in_ready;

	always_comb begin
		state_d  = state_q;
		dcmd     = '0;
		in_ready = 1'b0;
		case (state_q)
			hwm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (accept_c) begin
					case (cmd)
						hwm_pkg::CMD_SET_LEVEL: dcmd.wr_level = 1'b1;
						hwm_pkg::CMD_MIX: begin
							dcmd.start_mix = 1'b1;
							state_d        = hwm_pkg::ST_MIX;
						end
						hwm_pkg::CMD_READ: begin
							dcmd.rd_issue = 1'b1;
							state_d       = hwm_pkg::ST_READ;
						end
						default: ;
					endcase
				end
			end
			hwm_pkg::ST_MIX: begin
				if (sts.mix_done) begin
					dcmd.start_norm = 1'b1;
					state_d         = hwm_pkg::ST_NORM;
				end
			end
			hwm_pkg::ST_NORM: begin
				if (sts.norm_done) state_d = hwm_pkg::ST_IDLE;
			end
			hwm_pkg::ST_READ: begin
				// hold the fetched sample until the output register frees up
				if (!sts.out_valid || out_ready) begin
					dcmd.load_out = 1'b1;
					state_d       = hwm_pkg::ST_IDLE;
				end
			end
			default: state_d = hwm_pkg::ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// ----- src/hwm_datapath.sv -----
`default_nettype none
module hwm_datapath (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire hwm_pkg::dp_cmd_t                 dcmd,
	output hwm_pkg::dp_sts_t                      sts,
	input  wire logic [hwm_pkg::IDX_W-1:0]        index,
	input  wire logic signed [hwm_pkg::LEV_W-1:0] level,
	input  wire logic                             cfg_wr,
	input  wire logic [hwm_pkg::HC_W-1:0]         cfg_data,
	input  wire logic                             out_ready,
	output logic signed [hwm_pkg::SMP_W-1:0]      sample
);

	localparam int TS_W  = hwm_pkg::TS_W;
	localparam int MH_W  = hwm_pkg::MH_W;
	localparam int MIX_W = hwm_pkg::MIX_W;
	localparam int SMP_W = hwm_pkg::SMP_W;
	localparam logic [TS_W-1:0] P_LAST  = TS_W'(hwm_pkg::TABLE_SAMPLES - 1);
	localparam logic [TS_W:0]   PER_EXT = (TS_W + 1)'(hwm_pkg::PERIOD);
	localparam logic signed [MIX_W-1:0] SMP_MAX = MIX_W'((1 << (SMP_W - 1)) - 1);
	localparam logic signed [MIX_W-1:0] SMP_MIN = -MIX_W'(1 << (SMP_W - 1));

	// configuration and level store
	logic [hwm_pkg::HC_W-1:0]        hc_q;
	logic signed [hwm_pkg::LEV_W-1:0] level_q [hwm_pkg::MAX_HARMONICS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hc_q <= hwm_pkg::HC_W'(16);
			for (int i = 0; i < hwm_pkg::MAX_HARMONICS; i++) level_q[i] <= '0;
		end else begin
			if (cfg_wr) hc_q <= cfg_data;
			if (dcmd.wr_level && int'(index) < hwm_pkg::MAX_HARMONICS)
				level_q[MH_W'(index)] <= level;
		end
	end

	// mix sequencer
	logic            mix_run_q;
	logic [TS_W-1:0] p_q;
	logic [TS_W-1:0] k_q;
	logic [MH_W-1:0] j_q;
	logic [MH_W-1:0] nh_last_q;
	logic [MH_W-1:0] nh_last_c;
	logic [TS_W-1:0] pm_c;
	logic [TS_W:0]   p_inc_c;
	logic [TS_W:0]   k_sum_c;
	logic [TS_W-1:0] k_first_c;
	logic [TS_W-1:0] k_step_c;

	always_comb begin
		if (hc_q == '0) nh_last_c = '0;
		else if (int'(hc_q) > hwm_pkg::MAX_HARMONICS) nh_last_c = MH_W'(hwm_pkg::MAX_HARMONICS - 1);
		else nh_last_c = MH_W'(hc_q - 1'b1);
		pm_c      = (int'(p_q) == hwm_pkg::PERIOD) ? '0 : p_q;
		p_inc_c   = {1'b0, p_q} + 1'b1;
		k_first_c = (p_inc_c >= PER_EXT) ? '0 : p_inc_c[TS_W-1:0];
		k_sum_c   = {1'b0, k_q} + {1'b0, pm_c};
		k_step_c  = (k_sum_c >= PER_EXT) ? TS_W'(k_sum_c - PER_EXT) : k_sum_c[TS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mix_run_q <= 1'b0;
			p_q       <= '0;
			k_q       <= '0;
			j_q       <= '0;
			nh_last_q <= '0;
		end else if (dcmd.start_mix) begin
			mix_run_q <= 1'b1;
			p_q       <= '0;
			k_q       <= '0;
			j_q       <= '0;
			nh_last_q <= nh_last_c;
		end else if (mix_run_q) begin
			if (j_q == nh_last_q) begin
				j_q <= '0;
				if (p_q == P_LAST) begin
					mix_run_q <= 1'b0;
				end else begin
					p_q <= p_inc_c[TS_W-1:0];
					k_q <= k_first_c;
				end
			end else begin
				j_q <= j_q + 1'b1;
				k_q <= k_step_c;
			end
		end
	end

	// mix pipeline: table lookup, multiply, round and accumulate
	logic                              v_s1, v_s2;
	logic                              first_s1, first_s2;
	logic                              last_s1, last_s2;
	logic [TS_W-1:0]                   p_s1, p_s2;
	logic signed [hwm_pkg::SIN_W-1:0]  sin_s1;
	logic signed [hwm_pkg::LEV_W-1:0]  lev_s1;
	logic signed [31:0]                prod_s2;
	logic signed [32:0]                rnd_c;
	logic signed [17:0]                term_c;
	logic signed [MIX_W-1:0]           acc_q;
	logic signed [MIX_W-1:0]           sum_c;
	logic signed [MIX_W-1:0]           peak_q;
	logic                              mix_wr_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= mix_run_q;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		sin_s1   <= hwm_pkg::SINE_ROM[k_q];
		lev_s1   <= level_q[j_q];
		first_s1 <= (j_q == '0);
		last_s1  <= (j_q == nh_last_q);
		p_s1     <= p_q;
		prod_s2  <= lev_s1 * sin_s1;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		p_s2     <= p_s1;
	end

	always_comb begin
		rnd_c    = 33'(prod_s2) + 33'sd16384;
		term_c   = rnd_c[32:15];
		sum_c    = (first_s2 ? '0 : acc_q) + MIX_W'(term_c);
		mix_wr_c = v_s2 && last_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			peak_q <= '0;
		end else if (v_s2) begin
			acc_q <= sum_c;
			if (mix_wr_c) begin
				if (p_s2 == '0 || sum_c > peak_q) peak_q <= sum_c;
			end
		end
	end

	// mixed-sample buffer
	logic signed [MIX_W-1:0] mix_mem [hwm_pkg::TABLE_SAMPLES];
	logic signed [MIX_W-1:0] mix_rd_q;
	logic [TS_W-1:0]         n_q;

	always_ff @(posedge clk) begin
		if (mix_wr_c) mix_mem[p_s2] <= sum_c;
		mix_rd_q <= mix_mem[n_q];
	end

	// normalize sequencer with a restoring divider, one quotient bit per cycle
	hwm_pkg::norm_phase_t         phase_q;
	logic [hwm_pkg::DCNT_W-1:0]   dcnt_q;
	logic [hwm_pkg::NUM_W-1:0]    num_q;
	logic [hwm_pkg::REM_W-1:0]    rem_q;
	logic [hwm_pkg::DEN_W-1:0]    den_q;
	logic                         neg_q;
	logic [hwm_pkg::REM_W-1:0]    rem_sh_c;
	logic                         ge_c;
	logic [MIX_W-1:0]             abs_c;
	logic [hwm_pkg::NUM_W-1:0]    num_init_c;
	logic signed [SMP_W-1:0]      clamp_c;
	logic signed [SMP_W-1:0]      quot_c;
	logic signed [SMP_W-1:0]      norm_wd_c;
	logic                         norm_wr_c;
	logic                         adv_c;

	always_comb begin
		rem_sh_c   = {rem_q[hwm_pkg::REM_W-2:0], num_q[hwm_pkg::NUM_W-1]};
		ge_c       = rem_sh_c >= {1'b0, den_q};
		abs_c      = mix_rd_q[MIX_W-1] ? MIX_W'(-mix_rd_q) : MIX_W'(mix_rd_q);
		num_init_c = {1'b0, abs_c, 16'd0} + hwm_pkg::NUM_W'(peak_q);
		if (mix_rd_q > SMP_MAX) clamp_c = SMP_MAX[SMP_W-1:0];
		else if (mix_rd_q < SMP_MIN) clamp_c = SMP_MIN[SMP_W-1:0];
		else clamp_c = mix_rd_q[SMP_W-1:0];
		if (neg_q) begin
			if (num_q >= hwm_pkg::NUM_W'(1 << (SMP_W - 1))) quot_c = SMP_MIN[SMP_W-1:0];
			else quot_c = -SMP_W'(num_q);
		end else begin
			if (num_q >= hwm_pkg::NUM_W'((1 << (SMP_W - 1)) - 1)) quot_c = SMP_MAX[SMP_W-1:0];
			else quot_c = SMP_W'(num_q);
		end
		norm_wr_c = 1'b0;
		norm_wd_c = quot_c;
		if (phase_q == hwm_pkg::NP_SETUP && peak_q == '0) begin
			norm_wr_c = 1'b1;
			norm_wd_c = clamp_c;
		end else if (phase_q == hwm_pkg::NP_WRITE) begin
			norm_wr_c = 1'b1;
		end
		adv_c = norm_wr_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hwm_pkg::NP_IDLE;
			n_q     <= '0;
			dcnt_q  <= '0;
		end else begin
			case (phase_q)
				hwm_pkg::NP_IDLE: begin
					if (dcmd.start_norm) begin
						n_q     <= '0;
						phase_q <= hwm_pkg::NP_FETCH;
					end
				end
				hwm_pkg::NP_FETCH: phase_q <= hwm_pkg::NP_SETUP;
				hwm_pkg::NP_SETUP: begin
					if (peak_q != '0) begin
						dcnt_q  <= '0;
						phase_q <= hwm_pkg::NP_DIV;
					end
				end
				hwm_pkg::NP_DIV: begin
					dcnt_q <= dcnt_q + 1'b1;
					if (int'(dcnt_q) == hwm_pkg::DIV_STEPS - 1) phase_q <= hwm_pkg::NP_WRITE;
				end
				default: ;
			endcase
			if (adv_c) begin
				if (n_q == P_LAST) begin
					phase_q <= hwm_pkg::NP_IDLE;
				end else begin
					n_q     <= n_q + 1'b1;
					phase_q <= hwm_pkg::NP_FETCH;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == hwm_pkg::NP_SETUP) begin
			num_q <= num_init_c;
			rem_q <= '0;
			den_q <= {peak_q, 1'b0};
			neg_q <= mix_rd_q[MIX_W-1];
		end else if (phase_q == hwm_pkg::NP_DIV) begin
			num_q <= {num_q[hwm_pkg::NUM_W-2:0], ge_c};
			rem_q <= ge_c ? (rem_sh_c - {1'b0, den_q}) : rem_sh_c;
		end
	end

	// normalized table and read port
	logic signed [SMP_W-1:0] norm_mem [hwm_pkg::TABLE_SAMPLES];
	logic signed [SMP_W-1:0] norm_rd_q;
	logic                    built_q;
	logic                    oob_q;
	logic                    out_valid_q;
	logic signed [SMP_W-1:0] sample_q;

	always_ff @(posedge clk) begin
		if (norm_wr_c) norm_mem[n_q] <= norm_wd_c;
		if (dcmd.rd_issue) begin
			norm_rd_q <= norm_mem[TS_W'(index)];
			oob_q     <= int'(index) >= hwm_pkg::TABLE_SAMPLES;
		end
		if (dcmd.load_out) sample_q <= (built_q && !oob_q) ? norm_rd_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			built_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (dcmd.start_norm) built_q <= 1'b1;
			if (dcmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign sample        = sample_q;
	assign sts.out_valid = out_valid_q;
	assign sts.mix_done  = mix_wr_c && (p_s2 == P_LAST);
	assign sts.norm_done = adv_c && (n_q == P_LAST);

endmodule
`default_nettype wire

// ----- src/harmonic_wavetable_mixer_top.sv -----
// Additive wavetable builder. A transaction with cmd 0 stores one harmonic level (Q1.15),
// cmd 1 rebuilds the 256-sample table from the first harmonic_count levels (at least one,
// at most 16) and normalizes it to its peak, cmd 2 returns one normalized sample (Q5.15)
// on the output channel. A read registers the table entry, then moves it into the output
// register once that register is free; input is held off until then, which takes longer
// while an earlier sample still waits in the output register.
// A mix holds off input through accumulation (one multiply per harmonic and sample through
// a single multiplier, in two pipeline stages) and then a normalization pass through the
// bit-serial divider (clamping instead of dividing when the table's peak is zero).
// harmonic_count is written through the cfg channel, which is always ready.
`default_nettype none
module harmonic_wavetable_mixer_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [hwm_pkg::CMD_W-1:0]        cmd,
	input  wire logic [hwm_pkg::IDX_W-1:0]        index,
	input  wire logic signed [hwm_pkg::LEV_W-1:0] level,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic signed [hwm_pkg::SMP_W-1:0]      sample,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [hwm_pkg::HC_W-1:0]         cfg_data
);

	hwm_pkg::dp_cmd_t dcmd;
	hwm_pkg::dp_sts_t sts;

	assign cfg_ready = 1'b1;
	assign out_valid = sts.out_valid;

	hwm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.out_ready (out_ready),
		.sts       (sts),
		.dcmd      (dcmd)
	);

	hwm_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.dcmd      (dcmd),
		.sts       (sts),
		.index     (index),
		.level     (level),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.out_ready (out_ready),
		.sample    (sample)
	);

endmodule
`default_nettype wire

// ----- sim/harmonic_wavetable_mixer_top_tb.sv -----
module harmonic_wavetable_mixer_top_tb;

	localparam logic [hwm_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int MIX_LATENCY = 256 * hwm_pkg::MAX_HARMONICS + 4 + 256 * 44 + 64;
	localparam int STALL_LIMIT = 100000;

	typedef struct {
		logic [hwm_pkg::CMD_W-1:0]        op;
		logic [hwm_pkg::IDX_W-1:0]        idx;
		logic signed [hwm_pkg::LEV_W-1:0] lev;
	} synth_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [hwm_pkg::CMD_W-1:0] cmd = '0;
	logic [hwm_pkg::IDX_W-1:0] index = '0;
	logic signed [hwm_pkg::LEV_W-1:0] level = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [hwm_pkg::SMP_W-1:0] sample;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [hwm_pkg::HC_W-1:0] cfg_data = '0;

	synth_item_t pending_items[$];
	int expected_samples[$];
	int fail_count = 0;
	bit burst_mode = 0;
	int hold_epoch = 0;

	// predictor state
	int pred_levels[hwm_pkg::MAX_HARMONICS];
	int pred_table[hwm_pkg::TABLE_SAMPLES];
	int pred_count = 16;

	harmonic_wavetable_mixer_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .index(index), .level(level),
		.out_valid(out_valid), .out_ready(out_ready), .sample(sample),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	function automatic logic [63:0] q30_product(input logic [63:0] a, input logic [63:0] b);
		return (a * b + (64'd1 << 29)) >> 30;
	endfunction

	function automatic int wave_q15(input int k);
		logic [63:0] ph;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] v;
		ph = ((64'(k) << 32) + 64'd127) / 64'd255;
		x  = ph[30] ? ((64'd1 << 30) - {34'd0, ph[29:0]}) : {34'd0, ph[29:0]};
		x2 = q30_product(x, x);
		t  = 64'd5026995 - q30_product(x2, 64'd172272);
		t  = 64'd85569306 - q30_product(x2, t);
		t  = 64'd693598668 - q30_product(x2, t);
		t  = 64'd1686629713 - q30_product(x2, t);
		v  = (q30_product(x, t) + 64'd16384) >> 15;
		if (v > 64'd32767) v = 64'd32767;
		return ph[31] ? -int'(v) : int'(v);
	endfunction

	function automatic longint saturate(input longint v, input int bits);
		longint hi;
		hi = (longint'(1) << (bits - 1)) - 1;
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	function automatic int scale_to_peak(input int s, input int pk);
		longint num;
		longint mn;
		longint md;
		longint q;
		bit neg;
		num = longint'(s) * 32768;
		neg = (num < 0) != (pk < 0);
		mn  = num < 0 ? -num : num;
		md  = pk < 0 ? -longint'(pk) : longint'(pk);
		q   = (mn * 2 + md) / (md * 2);
		if (q > (longint'(1) << 40)) q = longint'(1) << 40;
		return int'(saturate(neg ? -q : q, hwm_pkg::SMP_W));
	endfunction

	task automatic rebuild_table();
		int sines[hwm_pkg::PERIOD];
		int mixed[hwm_pkg::TABLE_SAMPLES];
		int nh;
		int pk;
		longint acc;
		longint prod;
		nh = pred_count < 1 ? 1 :
			(pred_count > hwm_pkg::MAX_HARMONICS ? hwm_pkg::MAX_HARMONICS : pred_count);
		for (int p = 0; p < hwm_pkg::PERIOD; p++) sines[p] = wave_q15(p);
		for (int p = 0; p < hwm_pkg::TABLE_SAMPLES; p++) begin
			acc = 0;
			for (int j = 1; j <= nh; j++) begin
				prod = longint'(pred_levels[j-1]) * sines[(j * p) % hwm_pkg::PERIOD];
				acc += ((prod + (longint'(1) << 40) + 16384) >>> 15) - (longint'(1) << 25);
			end
			mixed[p] = int'(saturate(acc, hwm_pkg::MIX_W));
		end
		pk = mixed[0];
		for (int p = 1; p < hwm_pkg::TABLE_SAMPLES; p++) if (mixed[p] > pk) pk = mixed[p];
		for (int p = 0; p < hwm_pkg::TABLE_SAMPLES; p++)
			pred_table[p] = (pk == 0) ? int'(saturate(mixed[p], hwm_pkg::SMP_W))
				: scale_to_peak(mixed[p], pk);
	endtask

	task automatic apply_item(input logic [hwm_pkg::CMD_W-1:0] op,
			input logic [hwm_pkg::IDX_W-1:0] idx,
			input logic signed [hwm_pkg::LEV_W-1:0] lev);
		case (op)
			hwm_pkg::CMD_SET_LEVEL:
				if (idx < hwm_pkg::MAX_HARMONICS) pred_levels[idx] = int'(lev);
			hwm_pkg::CMD_MIX: rebuild_table();
			hwm_pkg::CMD_READ:
				expected_samples.insert(expected_samples.size(), pred_table[idx]);
			default: ;
		endcase
	endtask

	// driver
	int in_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		synth_item_t it;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap = 0;
		end else if (!(in_valid && !in_ready)) begin
			if (in_valid) begin
				apply_item(cmd, index, level);
				in_gap = burst_mode ? 0 : $urandom_range(0, 9);
			end
			if (in_gap != 0 || pending_items.size() == 0) begin
				in_valid <= 1'b0;
				if (in_gap != 0) in_gap--;
			end else begin
				it = pending_items.pop_front();
				in_valid <= 1'b1;
				cmd <= it.op;
				index <= it.idx;
				level <= it.lev;
			end
		end
	end

	// monitor
	int out_stall = 0;
	int hold_left = 0;
	int hold_seen = 0;
	always @(posedge clk or negedge arst_n) begin
		int want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_samples.size() == 0) begin
					$display("%0t: unexpected sample, expected none, actual %0d",
						$time, sample);
					fail_count++;
				end else begin
					want = expected_samples.pop_front();
					if (int'(sample) != want) begin
						$display("%0t: sample mismatch, expected %0d, actual %0d",
							$time, want, sample);
						fail_count++;
					end
				end
				out_stall = burst_mode ? 0 : $urandom_range(0, 9);
			end
			if (hold_seen != hold_epoch) begin
				hold_seen = hold_epoch;
				hold_left = 400;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (out_stall != 0) begin
				out_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	task automatic queue_item(input logic [hwm_pkg::CMD_W-1:0] op,
			input logic [hwm_pkg::IDX_W-1:0] idx,
			input logic signed [hwm_pkg::LEV_W-1:0] lev);
		synth_item_t it;
		it.op = op;
		it.idx = idx;
		it.lev = lev;
		pending_items.insert(pending_items.size(), it);
	endtask

	// sample settled values away from the active edge
	task automatic drain();
		@(negedge clk);
		while (pending_items.size() != 0 || in_valid || expected_samples.size() != 0)
			@(negedge clk);
		repeat (MIX_LATENCY) @(posedge clk);
	endtask

	task automatic write_count(input int v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= hwm_pkg::HC_W'(v);
		do @(posedge clk); while (!cfg_ready);
		pred_count = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_random(input int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 999);
			if (r < 15) queue_item(hwm_pkg::CMD_MIX, 8'($urandom), 16'($urandom));
			else if (r < 450)
				queue_item(hwm_pkg::CMD_SET_LEVEL,
					($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15)),
					16'($urandom));
			else if (r < 950) queue_item(hwm_pkg::CMD_READ, 8'($urandom), 16'($urandom));
			else queue_item(CMD_UNUSED, 8'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		int counts[6];
		counts = '{1, 0, 31, 7, 16, 3};
		for (int i = 0; i < hwm_pkg::MAX_HARMONICS; i++) pred_levels[i] = 0;
		for (int i = 0; i < hwm_pkg::TABLE_SAMPLES; i++) pred_table[i] = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reads before any mix, zero-peak mix, extremes, ignored commands
		queue_item(hwm_pkg::CMD_READ, 8'd0, 16'sd0);
		queue_item(hwm_pkg::CMD_READ, 8'd255, -16'sd1);
		queue_item(hwm_pkg::CMD_MIX, 8'd0, 16'sd0);
		queue_item(hwm_pkg::CMD_READ, 8'd77, 16'sd0);
		queue_item(hwm_pkg::CMD_SET_LEVEL, 8'd0, 16'sd32767);
		queue_item(hwm_pkg::CMD_SET_LEVEL, 8'd15, -16'sd32768);
		queue_item(hwm_pkg::CMD_SET_LEVEL, 8'd16, 16'sd1234);
		queue_item(hwm_pkg::CMD_SET_LEVEL, 8'd255, -16'sd1);
		queue_item(CMD_UNUSED, 8'd3, 16'sd5);
		queue_item(hwm_pkg::CMD_SET_LEVEL, 8'd7, -16'sd20000);
		queue_item(hwm_pkg::CMD_MIX, 8'd255, -16'sd1);
		queue_item(hwm_pkg::CMD_READ, 8'd0, 16'sd0);
		queue_item(hwm_pkg::CMD_READ, 8'd1, 16'sd0);
		queue_item(hwm_pkg::CMD_READ, 8'd64, 16'sd0);
		queue_item(hwm_pkg::CMD_READ, 8'd128, 16'sd0);
		queue_item(hwm_pkg::CMD_READ, 8'd254, 16'sd0);
		queue_item(hwm_pkg::CMD_READ, 8'd255, 16'sd0);
		queue_item(CMD_UNUSED, 8'd255, -16'sd1);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			write_count(counts[ph]);
			burst_mode = (ph % 3) == 2;
			queue_random(290);
			if (ph == 1) begin
				// stall the output while reads keep arriving so the block backs up
				for (int i = 0; i < 40; i++)
					queue_item(hwm_pkg::CMD_READ, 8'($urandom), 16'sd0);
				hold_epoch++;
			end
			drain();
		end

		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ----- files.f -----
src/hwm_pkg.sv
src/hwm_ctrl.sv
src/hwm_datapath.sv
src/harmonic_wavetable_mixer_top.sv
sim/harmonic_wavetable_mixer_top_tb.sv
